// ===== rtl/ficu_pkg.sv =====
package ficu_pkg;

  typedef enum logic [3:0] {
    OP_SI64F64 = 4'd0, OP_SI64F32 = 4'd1, OP_SI32F64 = 4'd2, OP_SI32F32 = 4'd3,
    OP_UI64F64 = 4'd4, OP_UI64F32 = 4'd5, OP_UI32F64 = 4'd6, OP_UI32F32 = 4'd7,
    OP_F64SI64 = 4'd8, OP_F64SI32 = 4'd9, OP_F32SI64 = 4'd10, OP_F32SI32 = 4'd11,
    OP_F64UI64 = 4'd12, OP_F64UI32 = 4'd13, OP_F32UI64 = 4'd14, OP_F32UI32 = 4'd15
  } op_t;

  // decoded per-item control carried down the pipe
  typedef struct packed {
    logic f2i;     // float to integer
    logic sgn;     // signed integer side
    logic wide;    // 64-bit integer side
    logic dbl;     // double precision float side
  } ctl_t;

  typedef struct packed {
    logic [63:0] result;
    logic        flags_valid;
    logic        int_overflow;
    logic        int_underflow;
    logic        int_error;
  } res_t;

  localparam int OUT_W = $bits(res_t);

  function automatic ctl_t decode(input logic [3:0] op);
    ctl_t c;
    c.f2i = op[3];
    if (!op[3]) begin
      c.sgn  = !op[2];
      c.wide = !op[1];
      c.dbl  = !op[0];
    end else begin
      c.sgn  = !op[2];
      c.dbl  = !op[1];
      c.wide = !op[0];
    end
    return c;
  endfunction

endpackage

// ===== rtl/ficu_i2f.sv =====
// Integer to float datapath: stage A magnitude, stage B normalize, stage C round/pack.
module ficu_i2f import ficu_pkg::*; (
  input  logic        clk,
  input  logic        en_a,
  input  logic        en_b,
  input  logic        en_c,
  input  ctl_t        ctl,
  input  logic [63:0] operand,
  output logic [63:0] result
);

  logic        a_neg;
  logic [63:0] a_mag;
  logic        a_dbl;
  logic        b_neg, b_dbl, b_zero;
  logic [63:0] b_norm;
  logic [5:0]  b_p;

  logic        neg_c;
  logic [63:0] mag_c;
  logic [31:0] lo;
  assign lo = operand[31:0];

  always_comb begin
    if (ctl.wide) begin
      neg_c = ctl.sgn && operand[63];
      mag_c = neg_c ? (64'd0 - operand) : operand;
    end else begin
      neg_c = ctl.sgn && lo[31];
      mag_c = {32'd0, neg_c ? (32'd0 - lo) : lo};
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_neg <= neg_c;
      a_mag <= mag_c;
      a_dbl <= ctl.dbl;
    end
  end

  // leading one position
  logic [5:0] lz;
  always_comb begin
    lz = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (a_mag[i]) lz = 6'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_neg  <= a_neg;
      b_dbl  <= a_dbl;
      b_zero <= (a_mag == 64'd0);
      b_p    <= lz;
      b_norm <= a_mag << (6'd63 - lz);
    end
  end

  // b_norm[63] is the leading one; round at the format's mantissa width
  logic [52:0] d_sig;
  logic        d_g, d_s;
  logic [53:0] d_r;
  logic [23:0] s_sig;
  logic        s_g, s_s;
  logic [24:0] s_r;
  logic [10:0] d_e;
  logic [7:0]  s_e;
  logic [63:0] packed_v;

  always_comb begin
    d_sig = b_norm[63:11];
    d_g   = b_norm[10];
    d_s   = |b_norm[9:0];
    d_r   = {1'b0, d_sig} + 54'((d_g && (d_s || d_sig[0])) ? 1 : 0);
    d_e   = 11'(b_p) + 11'd1023 + 11'(d_r[53]);
    s_sig = b_norm[63:40];
    s_g   = b_norm[39];
    s_s   = |b_norm[38:0];
    s_r   = {1'b0, s_sig} + 25'((s_g && (s_s || s_sig[0])) ? 1 : 0);
    s_e   = 8'(b_p) + 8'd127 + 8'(s_r[24]);
    if (b_zero) begin
      packed_v = 64'd0;
    end else if (b_dbl) begin
      packed_v = {b_neg, d_e, d_r[53] ? d_r[52:1] : d_r[51:0]};
    end else begin
      packed_v = {32'd0, b_neg, s_e, s_r[24] ? s_r[23:1] : s_r[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en_c) result <= packed_v;
  end

endmodule

// ===== rtl/ficu_f2i.sv =====
// Float to integer datapath: stage A unpack/range, stage B shift, stage C negate.
module ficu_f2i import ficu_pkg::*; (
  input  logic        clk,
  input  logic        en_a,
  input  logic        en_b,
  input  logic        en_c,
  input  ctl_t        ctl,
  input  logic [63:0] operand,
  output logic [63:0] result,
  output logic        ovf,
  output logic        unf
);

  logic [10:0] ex;
  logic [51:0] frac;
  logic        neg, emax, nan;
  logic signed [12:0] e;
  logic signed [12:0] lim;
  logic        o_c, u_c, zero_c;

  always_comb begin
    if (ctl.dbl) begin
      ex   = operand[62:52];
      frac = operand[51:0];
      neg  = operand[63];
      emax = &operand[62:52];
      e    = $signed({2'b0, operand[62:52]}) - 13'sd1023;
    end else begin
      ex   = {3'd0, operand[30:23]};
      frac = {operand[22:0], 29'd0};
      neg  = operand[31];
      emax = &operand[30:23];
      e    = $signed({5'b0, operand[30:23]}) - 13'sd127;
    end
    nan = emax && (frac != 52'd0);
    lim = ctl.wide ? 13'sd63 : 13'sd31;
    if (nan) begin
      o_c = 1'b1;
      u_c = 1'b1;
    end else if (ctl.sgn) begin
      o_c = !neg && (emax || e >= lim);
      u_c = neg && (emax || e > lim || (e == lim && frac != 52'd0));
    end else begin
      o_c = !neg && (emax || e >= lim + 13'sd1);
      u_c = neg && (ex != 11'd0 || frac != 52'd0);
    end
    zero_c = o_c || u_c || ex == 11'd0 || e < 13'sd0;
  end

  logic [52:0] a_sig;
  logic [5:0]  a_e;
  logic        a_zero, a_neg, a_wide, a_o, a_u;

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_sig  <= {1'b1, frac};
      a_e    <= e[5:0];
      a_zero <= zero_c;
      a_neg  <= neg;
      a_wide <= ctl.wide;
      a_o    <= o_c;
      a_u    <= u_c;
    end
  end

  // value = sig * 2^(e-52), e in 0..63
  logic [115:0] sh;
  assign sh = {63'd0, a_sig} << a_e;

  logic [63:0] b_mag;
  logic        b_neg, b_wide, b_o, b_u;
  always_ff @(posedge clk) begin
    if (en_b) begin
      b_mag  <= a_zero ? 64'd0 : sh[115:52];
      b_neg  <= a_neg;
      b_wide <= a_wide;
      b_o    <= a_o;
      b_u    <= a_u;
    end
  end

  logic [63:0] m;
  always_comb begin
    m = b_neg ? (64'd0 - b_mag) : b_mag;
    if (!b_wide) m = {32'd0, m[31:0]};
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      result <= m;
      ovf    <= b_o;
      unf    <= b_u;
    end
  end

endmodule

// ===== rtl/float_int_convert_unit.sv =====
// Channel  Dir  tdata                              tuser
// s_axis   in   [63:0] operand                     [3:0] op
// m_axis   out  [63:0] result                      [0] flags_valid [1] int_overflow
//                                                  [2] int_underflow [3] int_error
// One item per cycle unless m_axis_tready stalls the output; three datapath stages and an output register.
// Every stage advances only when the stage ahead is free, so a stall holds data in place.
// rst clears the valid bits only; the unit keeps no other state.
module float_int_convert_unit import ficu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] operand
  input  logic [3:0]  s_axis_tuser,   // [3:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] result
  output logic [3:0]  m_axis_tuser    // flags_valid, int_overflow, int_underflow, int_error
);

  logic v_a, v_b, v_c;
  logic en_a, en_b, en_c, en_o;
  logic f2i_a, f2i_b, f2i_c;
  ctl_t ctl;
  logic [63:0] i2f_res, f2i_res;
  logic ovf, unf;
  res_t out_r, out_next;

  assign ctl  = decode(s_axis_tuser);
  assign en_o = !m_axis_tvalid || m_axis_tready;
  assign en_c = !v_c || en_o;
  assign en_b = !v_b || en_c;
  assign en_a = !v_a || en_b;
  assign s_axis_tready = en_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (en_a) v_a <= s_axis_tvalid;
      if (en_b) v_b <= v_a;
      if (en_c) v_c <= v_b;
      if (en_o) m_axis_tvalid <= v_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) f2i_a <= ctl.f2i;
    if (en_b) f2i_b <= f2i_a;
    if (en_c) f2i_c <= f2i_b;
  end

  ficu_i2f u_i2f (.clk, .en_a, .en_b, .en_c, .ctl, .operand(s_axis_tdata), .result(i2f_res));
  ficu_f2i u_f2i (.clk, .en_a, .en_b, .en_c, .ctl, .operand(s_axis_tdata),
                  .result(f2i_res), .ovf, .unf);

  always_comb begin
    out_next.flags_valid   = f2i_c;
    out_next.int_overflow  = f2i_c && ovf && !unf;
    out_next.int_underflow = f2i_c && unf && !ovf;
    out_next.int_error     = f2i_c && ovf && unf;
    if (!f2i_c) out_next.result = i2f_res;
    else if (ovf || unf) out_next.result = 64'd0;
    else out_next.result = f2i_res;
  end

  always_ff @(posedge clk) begin
    if (en_o) out_r <= out_next;
  end

  assign m_axis_tdata = out_r.result;
  assign m_axis_tuser = {out_r.int_error, out_r.int_underflow, out_r.int_overflow,
                         out_r.flags_valid};

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser[1] || m_axis_tuser[2] || m_axis_tuser[3])
      |-> m_axis_tdata == 64'd0) else $error("flagged result not zero");
  a_flags_one: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> $onehot0(m_axis_tuser[3:1])) else $error("flags not exclusive");
  a_flags_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tuser[3:1] == 3'd0)
    else $error("flags on integer to float op");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule
